// ===== sv/ptt_pkg.sv =====
// Shared types and codes for the periodic task timer table.
// Holds the entry layout, command and result codes, and the result handshake structs.
// No dependencies.
package ptt_pkg;

    localparam int TIME_W   = 48;
    localparam int ID_W     = 16;
    localparam int PERIOD_W = 31;
    localparam int DUE_W    = 32;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUE       = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   next_time;
        logic [PERIOD_W-1:0] period;
        logic                one_shot;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] next_time;
    } res_t;

    // Requests from the sequencer to the result stage.
    typedef struct packed {
        logic rec_valid;   // a due record that may be followed by more
        logic flush;       // end of a tick scan: release the held record as last
        logic fin_valid;   // a single final result
        res_t rec;
        res_t fin;
    } res_req_t;

    typedef struct packed {
        logic rec_ready;
        logic flush_ready;
        logic fin_ready;
    } res_stat_t;

endpackage

// ===== sv/ptt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the timer entry store. No dependencies.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/ptt_result.sv =====
// Result stage: one held due record plus the output register.
// Depends on ptt_pkg for the result record and handshake structs.
module ptt_result (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptt_pkg::res_req_t            req,
    output ptt_pkg::res_stat_t           stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptt_pkg::KIND_W-1:0]   kind,
    output logic [ptt_pkg::ID_W-1:0]     entry_id,
    output logic [ptt_pkg::TIME_W-1:0]   next_time,
    output logic                         last
);
    import ptt_pkg::*;

    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;
    logic  out_last_reg, out_last_next;
    logic  hold_v_reg, hold_v_next;
    res_t  hold_reg, hold_next;
    logic  out_free;

    // A due record is held back in a register so that the last one of a tick
    // can be marked when the scan ends.
    assign out_free         = !out_valid_reg || out_ready;
    assign stat.rec_ready   = !hold_v_reg || out_free;
    assign stat.flush_ready = !hold_v_reg || out_free;
    assign stat.fin_ready   = out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        hold_v_next    = hold_v_reg;
        hold_next      = hold_reg;
        if (req.rec_valid && stat.rec_ready)
        begin
            if (hold_v_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_v_next = 1'b1;
            hold_next   = req.rec;
        end
        else if (req.flush && hold_v_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_next       = hold_reg;
            out_last_next  = 1'b1;
            hold_v_next    = 1'b0;
        end
        else if (req.fin_valid && out_free)
        begin
            out_valid_next = 1'b1;
            out_next       = req.fin;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_v_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hold_v_reg    <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        hold_reg     <= hold_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign entry_id  = out_reg.entry_id;
    assign next_time = out_reg.next_time;
    assign last      = out_last_reg;

endmodule

// ===== sv/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: command sequencer and entry scan.
// Depends on ptt_pkg, ptt_ram and ptt_result.
//
// Usage: commands arrive on the input channel (in_valid/in_ready) and results
// leave on the output channel (out_valid/out_ready); each channel moves one
// transfer when valid and ready are both high. The entries live in one RAM of
// SLOTS words, kept in insertion order.
// An add answers in the cycle after its transfer with "added" or "table full".
// A remove or a tick scans the table once: one entry is read per cycle and
// written back at a compaction pointer, so deleted entries close up in the
// same pass. A remove gives one result at the end of the scan; a tick gives
// one result per due entry, the final one carrying last. A tick with nothing
// due gives none. One command is worked on at a time; in_ready is low during
// a scan. A stalled receiver freezes the scan; one due record is held
// internally so that last can be marked on the final one.
// Reset empties the table, sets the next ID to one and the clock to zero;
// no clearing pass is needed.
module periodic_task_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ptt_pkg::CMD_W-1:0]    cmd,
    input  logic [ptt_pkg::DUE_W-1:0]    due_time,
    input  logic [ptt_pkg::PERIOD_W-1:0] period,
    input  logic                         one_shot,
    input  logic [ptt_pkg::ID_W-1:0]     task_id,
    input  logic [ptt_pkg::TIME_W-1:0]   now_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptt_pkg::KIND_W-1:0]   kind,
    output logic [ptt_pkg::ID_W-1:0]     entry_id,
    output logic [ptt_pkg::TIME_W-1:0]   next_time,
    output logic                         last
);
    import ptt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  op_reg, op_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic              pv_reg, pv_next;
    logic              found_reg, found_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [TIME_W-1:0] tick_reg, tick_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    entry_t            ent;

    res_req_t          req;
    res_stat_t         stat;

    logic              accept;
    logic              is_due;
    logic              is_match;
    logic              keep;
    logic              emit;
    logic              go;
    logic              drained;
    logic [TIME_W-1:0] resched;
    logic [TIME_W-1:0] add_time;
    logic [ID_W-1:0]   id_inc;

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ent)
    );

    ptt_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .entry_id  (entry_id),
        .next_time (next_time),
        .last      (last)
    );

    assign in_ready = (state_reg == ST_IDLE) && stat.fin_ready;
    assign accept   = in_valid && in_ready;

    assign resched  = tick_reg + {{(TIME_W - PERIOD_W){1'b0}}, ent.period};
    assign add_time = tick_reg + {{(TIME_W - DUE_W){1'b0}}, due_time};
    assign id_inc   = next_id_reg + ID_W'(1);

    // Read data entry is processed this cycle if pv_reg is set and not stalled.
    assign is_due   = (op_reg == CMD_TICK) && (ent.next_time <= tick_reg);
    assign is_match = (op_reg == CMD_REMOVE) && !found_reg && (ent.id == tid_reg);
    assign keep     = !(is_match || (is_due && ent.one_shot));
    assign emit     = is_due;
    assign go       = pv_reg && (!emit || stat.rec_ready);
    assign drained  = (state_reg == ST_SCAN) && !pv_reg && (rd_ptr_reg == cnt_reg);
    assign ram_re   = (state_reg == ST_SCAN) && (rd_ptr_reg < cnt_reg) && (!pv_reg || go);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        pv_next      = pv_reg;
        found_next   = found_reg;
        tid_next     = tid_reg;
        next_id_next = next_id_reg;
        tick_next    = tick_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[AW-1:0];
        ram_wdata = ent;
        if (is_due)
        begin
            ram_wdata.next_time = resched;
        end

        req           = '0;
        req.rec       = '{kind: KIND_DUE, entry_id: ent.id, next_time: resched};
        req.rec_valid = pv_reg && emit;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ADD:
                        begin
                            req.fin_valid = 1'b1;
                            if (cnt_reg == CW'(SLOTS))
                            begin
                                req.fin = '{kind: KIND_FULL, entry_id: '0, next_time: '0};
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[AW-1:0];
                                ram_wdata = '{id: next_id_reg, next_time: add_time,
                                              period: period, one_shot: one_shot};
                                req.fin   = '{kind: KIND_ADDED, entry_id: next_id_reg,
                                              next_time: add_time};
                                cnt_next  = cnt_reg + CW'(1);
                                next_id_next = (id_inc == '0) ? ID_W'(1) : id_inc;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            op_next     = cmd;
                            tid_next    = task_id;
                            found_next  = 1'b0;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            pv_next     = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        CMD_TICK:
                        begin
                            op_next     = cmd;
                            tick_next   = now_time;
                            found_next  = 1'b0;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            pv_next     = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    if (keep)
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CW'(1);
                    end
                    if (is_match)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (ram_re)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    pv_next     = 1'b1;
                end
                else if (go)
                begin
                    pv_next = 1'b0;
                end
                if (drained)
                begin
                    if (op_reg == CMD_REMOVE)
                    begin
                        req.fin_valid = 1'b1;
                        if (found_reg)
                        begin
                            req.fin = '{kind: KIND_REMOVED, entry_id: tid_reg,
                                        next_time: '0};
                        end
                        else
                        begin
                            req.fin = '{kind: KIND_NOT_FOUND, entry_id: '0,
                                        next_time: '0};
                        end
                        if (stat.fin_ready)
                        begin
                            cnt_next   = wr_ptr_reg;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        req.flush = 1'b1;
                        if (stat.flush_ready)
                        begin
                            cnt_next   = wr_ptr_reg;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= CMD_ADD;
            cnt_reg     <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            pv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            next_id_reg <= ID_W'(1);
            tick_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cnt_reg     <= cnt_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            pv_reg      <= pv_next;
            found_reg   <= found_next;
            next_id_reg <= next_id_next;
            tick_reg    <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
    end

endmodule
